// ===== hw/rtl/bmp_pkg.sv =====
// ----------------------------------------------------------------------------
// bmp_pkg
// Shared constants for the binomial coefficient mod prime block.
// ----------------------------------------------------------------------------
package bmp_pkg;

  localparam int N_W         = 12;
  localparam int VAL_W       = 30;
  localparam int TABLE_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int MUL_LAT     = 4;

  localparam logic [VAL_W-1:0] MOD_P     = 30'd1000000007;
  localparam logic [VAL_W-1:0] FERMAT_E  = MOD_P - 30'd2;
  localparam logic [31:0]      MOD_P_32  = 32'(MOD_P);
  localparam logic [31:0]      MOD_2P_32 = 32'(MOD_P) * 32'd2;
  // floor(2^60 / p) for Barrett reduction
  localparam logic [63:0]      BARRETT_64 = 64'h1000_0000_0000_0000 / 64'd1000000007;
  localparam logic [30:0]      BARRETT_M  = BARRETT_64[30:0];

endpackage

// ===== hw/rtl/bmp_modmul.sv =====
// ----------------------------------------------------------------------------
// bmp_modmul
// Pipelined modular multiplier, Barrett reduction by p, four stages.
// ----------------------------------------------------------------------------
module bmp_modmul import bmp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [VAL_W-1:0] a,
  input  logic [VAL_W-1:0] b,
  output logic             out_valid,
  output logic [VAL_W-1:0] res
);

  logic [MUL_LAT-1:0] vld;
  logic [59:0]        x1;
  logic [30:0]        q;
  logic [31:0]        xl;
  logic [31:0]        r;
  logic [61:0]        q_full;

  assign q_full = 62'(x1[59:29]) * 62'(BARRETT_M);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[MUL_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= 60'(a) * 60'(b);
      q  <= q_full[61:31];
      xl <= x1[31:0];
      r  <= xl - (32'(q) * MOD_P_32);
      if (r >= MOD_2P_32) begin
        res <= 30'(r - MOD_2P_32);
      end else if (r >= MOD_P_32) begin
        res <= 30'(r - MOD_P_32);
      end else begin
        res <= 30'(r);
      end
    end
  end

  assign out_valid = vld[MUL_LAT-1];

endmodule

// ===== hw/rtl/binomial_mod_prime_top.sv =====
// ----------------------------------------------------------------------------
// binomial_mod_prime_top
// C(n,k) mod 1000000007 from factorial and inverse-factorial memories.
// ----------------------------------------------------------------------------
// Input channel: in_valid/in_stall carry n_total and k_chosen. Output channel:
// out_valid/out_stall carry value and k_too_large, one result per query.
// After reset the block fills its tables: a forward pass of factorials, one
// Fermat exponentiation of the last factorial (30 squarings plus multiplies),
// and a backward pass of inverse factorials. Each step uses the shared
// four-stage multiplier and waits for its result before the next step is
// issued; in_stall is high throughout.
// Once filled, one query is accepted per cycle while the output is not
// stalled. From acceptance to out_valid a query passes the memory read at
// the accepting edge, two chained four-stage modular multipliers, and the
// output register. When the receiver stalls, the whole query pipeline holds
// and in_stall rises until the output is taken.
// k greater than n yields value 0 with k_too_large set.
// ----------------------------------------------------------------------------
module binomial_mod_prime_top import bmp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [N_W-1:0]   n_total,
  input  logic [N_W-1:0]   k_chosen,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [VAL_W-1:0] value,
  output logic             k_too_large
);

  typedef enum logic [2:0] {S_FWD, S_POW_SQ, S_POW_MUL, S_BWD, S_READY} state_t;

  state_t              state;
  logic [ADDR_W-1:0]   idx;
  logic                busy;
  logic [VAL_W-1:0]    f_cur;
  logic [VAL_W-1:0]    acc;
  logic [4:0]          ebit;

  logic [VAL_W-1:0] fact_mem [TABLE_DEPTH];
  logic [VAL_W-1:0] inv_mem  [TABLE_DEPTH];

  logic               ready;
  logic               adv;
  logic               issue;
  logic [VAL_W-1:0]   fa;
  logic [VAL_W-1:0]   fb;
  logic               fact_we;
  logic               inv_we;
  logic [ADDR_W-1:0]  inv_wa;
  logic               pow_last;

  logic               ma_en;
  logic               ma_iv;
  logic [VAL_W-1:0]   ma_a;
  logic [VAL_W-1:0]   ma_b;
  logic               ma_ov;
  logic [VAL_W-1:0]   ma_res;
  logic               mb_ov;
  logic [VAL_W-1:0]   mb_res;

  logic [16:0]        n_wide;
  logic [16:0]        k_wide;
  logic [16:0]        nk_wide;
  logic [N_W-1:0]     nk;

  logic                   v1;
  logic [VAL_W-1:0]       rd_f;
  logic [VAL_W-1:0]       rd_k;
  logic [VAL_W-1:0]       rd_nk;
  logic                   tl1;
  logic                   zr1;
  logic [VAL_W-1:0]       nk_d [MUL_LAT];
  logic [2*MUL_LAT-1:0]   tl_d;
  logic [2*MUL_LAT-1:0]   zr_d;

  assign ready    = (state == S_READY);
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !ready || !adv;
  assign issue    = !busy && !ready;

  always_comb begin
    fa = acc;
    fb = acc;
    unique case (state)
      S_FWD: begin
        fa = f_cur;
        fb = (idx == '0) ? VAL_W'(1) : VAL_W'(idx);
      end
      S_POW_SQ:  fb = acc;
      S_POW_MUL: fb = f_cur;
      S_BWD:     fb = VAL_W'(idx);
      S_READY:   fb = acc;
      default:   fb = acc;
    endcase
  end

  assign pow_last = ma_ov && (ebit == '0) &&
                    ((state == S_POW_MUL) || (state == S_POW_SQ && !FERMAT_E[ebit]));
  assign fact_we  = (state == S_FWD) && ma_ov;
  assign inv_we   = pow_last || ((state == S_BWD) && ma_ov);
  assign inv_wa   = (state == S_BWD) ? idx - ADDR_W'(1) : ADDR_W'(TABLE_DEPTH - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FWD;
      idx   <= '0;
      busy  <= 1'b0;
      f_cur <= VAL_W'(1);
      acc   <= VAL_W'(1);
      ebit  <= '0;
    end else begin
      if (issue) begin
        busy <= 1'b1;
      end
      if (ma_ov && !ready) begin
        busy <= 1'b0;
        unique case (state)
          S_FWD: begin
            f_cur <= ma_res;
            if (idx == ADDR_W'(TABLE_DEPTH - 1)) begin
              state <= S_POW_SQ;
              acc   <= VAL_W'(1);
              ebit  <= 5'(VAL_W - 1);
            end else begin
              idx <= idx + ADDR_W'(1);
            end
          end
          S_POW_SQ: begin
            acc <= ma_res;
            if (FERMAT_E[ebit]) begin
              state <= S_POW_MUL;
            end else if (ebit == '0) begin
              state <= S_BWD;
              idx   <= ADDR_W'(TABLE_DEPTH - 1);
            end else begin
              ebit <= ebit - 5'd1;
            end
          end
          S_POW_MUL: begin
            acc <= ma_res;
            if (ebit == '0) begin
              state <= S_BWD;
              idx   <= ADDR_W'(TABLE_DEPTH - 1);
            end else begin
              ebit  <= ebit - 5'd1;
              state <= S_POW_SQ;
            end
          end
          S_BWD: begin
            acc <= ma_res;
            if (idx == ADDR_W'(1)) begin
              state <= S_READY;
            end else begin
              idx <= idx - ADDR_W'(1);
            end
          end
          S_READY: state <= S_READY;
          default: state <= S_FWD;
        endcase
      end
    end
  end

  assign n_wide  = 17'(n_total);
  assign k_wide  = 17'(k_chosen);
  assign nk      = n_total - k_chosen;
  assign nk_wide = 17'(nk);

  always_ff @(posedge clk) begin
    if (fact_we) begin
      fact_mem[idx] <= ma_res;
    end
    if (inv_we) begin
      inv_mem[inv_wa] <= ma_res;
    end
    if (adv) begin
      rd_f  <= fact_mem[n_wide[ADDR_W-1:0]];
      rd_k  <= inv_mem[k_wide[ADDR_W-1:0]];
      rd_nk <= inv_mem[nk_wide[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tl1 <= (k_chosen > n_total);
      zr1 <= (n_wide >= 17'(TABLE_DEPTH));
      nk_d[0] <= rd_nk;
      for (int i = 1; i < MUL_LAT; i++) begin
        nk_d[i] <= nk_d[i-1];
      end
      tl_d <= {tl_d[2*MUL_LAT-2:0], tl1};
      zr_d <= {zr_d[2*MUL_LAT-2:0], zr1};
      value       <= (tl_d[2*MUL_LAT-1] || zr_d[2*MUL_LAT-1]) ? '0 : mb_res;
      k_too_large <= tl_d[2*MUL_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid && ready;
      out_valid <= mb_ov;
    end
  end

  assign ma_en = !ready || adv;
  assign ma_iv = ready ? v1 : issue;
  assign ma_a  = ready ? rd_f : fa;
  assign ma_b  = ready ? rd_k : fb;

  bmp_modmul u_mul_a (
    .clk       (clk),
    .rst       (rst),
    .en        (ma_en),
    .in_valid  (ma_iv),
    .a         (ma_a),
    .b         (ma_b),
    .out_valid (ma_ov),
    .res       (ma_res)
  );

  bmp_modmul u_mul_b (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (ma_ov && ready),
    .a         (ma_res),
    .b         (nk_d[MUL_LAT-1]),
    .out_valid (mb_ov),
    .res       (mb_res)
  );

endmodule
